@@ rtl/core/tot_weighted_centroid_min_tdc_unit_defines.svh @@
// ----------------------------------------------------------------------------
// tot_weighted_centroid_min_tdc_unit assertion macros
// clocked assertion helpers shared by the centroid unit modules
// ----------------------------------------------------------------------------
`ifndef TOT_WEIGHTED_CENTROID_MIN_TDC_UNIT_DEFINES_SVH
`define TOT_WEIGHTED_CENTROID_MIN_TDC_UNIT_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define TWC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assertion on the module's clk_i and rst_ni
`define TWC_ASSERT(lbl, prop, msg) \
  `TWC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/twc_pkg.sv @@
// ----------------------------------------------------------------------------
// twc_pkg
// shared types and constants of the tot weighted centroid unit
// ----------------------------------------------------------------------------
package twc_pkg;

  // field widths
  localparam int unsigned LAYER_W  = 3;
  localparam int unsigned TDC_W    = 16;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned CEN_W    = 16;
  localparam int unsigned TOT_OP_W = TDC_W + 1;
  localparam int unsigned PROD_W   = TOT_OP_W + POS_W;
  localparam int unsigned TOT_W    = 24;
  localparam int unsigned WSUM_W   = 40;
  localparam int unsigned DIVCNT_W = $clog2(WSUM_W);

  // stream payload layout
  localparam int unsigned IN_LAYER_LSB = 0;
  localparam int unsigned IN_LEAD_LSB  = IN_LAYER_LSB + LAYER_W;
  localparam int unsigned IN_TRAIL_LSB = IN_LEAD_LSB + TDC_W;
  localparam int unsigned IN_WIRE_LSB  = IN_TRAIL_LSB + TDC_W;
  localparam int unsigned IN_DATA_W    = 56;
  localparam int unsigned OUT_DATA_W   = 64;
  localparam int unsigned OUT_USER_W   = 3;

  // defaults for the top level parameters
  localparam int unsigned MAX_HITS_DEF   = 64;
  localparam int unsigned NUM_LAYERS_DEF = 6;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_U_POS = 2'd0,
    CFG_U_TIM = 2'd1,
    CFG_V_POS = 2'd2,
    CFG_V_TIM = 2'd3
  } twc_cfg_idx_e;

  localparam logic [LAYER_W-1:0] CFG_RST_U_POS = 3'd0;
  localparam logic [LAYER_W-1:0] CFG_RST_U_TIM = 3'd2;
  localparam logic [LAYER_W-1:0] CFG_RST_V_POS = 3'd3;
  localparam logic [LAYER_W-1:0] CFG_RST_V_TIM = 3'd5;

  typedef struct packed {
    logic [LAYER_W-1:0] u_pos;
    logic [LAYER_W-1:0] u_tim;
    logic [LAYER_W-1:0] v_pos;
    logic [LAYER_W-1:0] v_tim;
  } twc_cfg_t;

  // classified hit handed from front to back
  typedef struct packed {
    logic                       last;
    logic                       hit;
    logic                       u_pos;
    logic                       u_tim;
    logic                       v_pos;
    logic                       v_tim;
    logic [TDC_W-1:0]           lead;
    logic signed [TOT_OP_W-1:0] tot;
    logic signed [POS_W-1:0]    wire_pos;
  } twc_op_t;

  // per-plane accumulator
  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [TOT_W-1:0]  tot;
    logic [TDC_W-1:0]  min_tdc;
    logic              found;
  } twc_plane_t;

  localparam twc_plane_t PLANE_CLR = '{wsum: '0, tot: '0, min_tdc: '1, found: 1'b0};

  // divider handshake
  typedef struct packed {
    logic start;
    logic ack;
  } twc_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } twc_div_stat_t;

endpackage

@@ rtl/core/twc_fifo.sv @@
// ----------------------------------------------------------------------------
// twc_fifo
// short queue of classified hits between front and back
// ----------------------------------------------------------------------------
`include "tot_weighted_centroid_min_tdc_unit_defines.svh"

module twc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  twc_pkg::twc_op_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output twc_pkg::twc_op_t data_o,
  output logic            empty_o
);
  import twc_pkg::*;

  twc_op_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]     count_q, count_d;

  assign full_o  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `TWC_ASSERT(a_fifo_no_overrun, push_i |-> !full_o || pop_i, "push into full queue")
  `TWC_ASSERT(a_fifo_no_underrun, pop_i |-> !empty_o, "pop from empty queue")
  `TWC_ASSERT(a_fifo_count_max, count_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH), "queue count past depth")

endmodule

@@ rtl/core/twc_front.sv @@
// ----------------------------------------------------------------------------
// twc_front
// takes hits from the stream and classifies them per plane role
// ----------------------------------------------------------------------------
module twc_front #(
  parameter int unsigned NUM_LAYERS = twc_pkg::NUM_LAYERS_DEF
) (
  input  twc_pkg::twc_cfg_t              cfg_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [twc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           s_axis_tuser,
  input  logic                           full_i,
  output logic                           push_o,
  output twc_pkg::twc_op_t               op_o
);
  import twc_pkg::*;

  logic [LAYER_W-1:0] layer;
  logic [TDC_W-1:0]   lead, trail;
  logic               in_range, lead_pos, hit;

  assign layer = s_axis_tdata[IN_LEAD_LSB-1:IN_LAYER_LSB];
  assign lead  = s_axis_tdata[IN_TRAIL_LSB-1:IN_LEAD_LSB];
  assign trail = s_axis_tdata[IN_WIRE_LSB-1:IN_TRAIL_LSB];

  assign in_range = ({1'b0, layer} < (LAYER_W+1)'(NUM_LAYERS));
  assign lead_pos = (lead != '0);
  assign hit      = s_axis_tuser;

  assign s_axis_tready = !full_i;
  // items with neither hit nor event end change nothing and are dropped
  assign push_o = s_axis_tvalid && !full_i && (hit || s_axis_tlast);

  always_comb begin
    op_o.last     = s_axis_tlast;
    op_o.hit      = hit;
    op_o.u_pos    = hit && in_range && (layer == cfg_i.u_pos);
    op_o.u_tim    = hit && in_range && lead_pos && (layer == cfg_i.u_tim);
    op_o.v_pos    = hit && in_range && (layer == cfg_i.v_pos);
    op_o.v_tim    = hit && in_range && lead_pos && (layer == cfg_i.v_tim);
    op_o.lead     = lead;
    op_o.tot      = $signed({1'b0, trail}) - $signed({1'b0, lead});
    op_o.wire_pos = $signed(s_axis_tdata[IN_WIRE_LSB+POS_W-1:IN_WIRE_LSB]);
  end

endmodule

@@ rtl/core/twc_div.sv @@
// ----------------------------------------------------------------------------
// twc_div
// bit-serial signed divider, one quotient bit per cycle, saturated result
// ----------------------------------------------------------------------------
module twc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  twc_pkg::twc_div_ctrl_t        ctrl_i,
  input  logic [twc_pkg::WSUM_W-1:0]    dividend_i,
  input  logic [twc_pkg::TOT_W-1:0]     divisor_i,
  output twc_pkg::twc_div_stat_t        stat_o,
  output logic [twc_pkg::CEN_W-1:0]     quot_o
);
  import twc_pkg::*;

  localparam logic [DIVCNT_W-1:0] DIV_LAST = DIVCNT_W'(WSUM_W - 1);
  localparam logic [WSUM_W-1:0]   POS_LIM  = WSUM_W'((2 ** (CEN_W - 1)) - 1);
  localparam logic [WSUM_W-1:0]   NEG_LIM  = WSUM_W'(2 ** (CEN_W - 1));
  localparam logic [CEN_W-1:0]    POS_SAT  = {1'b0, {(CEN_W-1){1'b1}}};
  localparam logic [CEN_W-1:0]    NEG_SAT  = {1'b1, {(CEN_W-1){1'b0}}};

  logic                busy_q, done_q;
  logic [DIVCNT_W-1:0] cnt_q;
  logic [TOT_W-1:0]    rem_q, rem_d, div_q;
  logic [WSUM_W-1:0]   quo_q, quo_d, mag;
  logic                neg_q;
  logic [TOT_W:0]      rem_sh;
  logic                ge;

  assign mag    = dividend_i[WSUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign rem_sh = {rem_q, quo_q[WSUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_q});
  // restoring step, remainder stays below the divisor
  assign rem_d  = ge ? TOT_W'(rem_sh - {1'b0, div_q}) : rem_sh[TOT_W-1:0];
  assign quo_d  = {quo_q[WSUM_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (ctrl_i.ack) begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[WSUM_W-1];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // magnitude quotient back to signed, clamped to the output range
  always_comb begin
    if (!neg_q) begin
      quot_o = (quo_q > POS_LIM) ? POS_SAT : quo_q[CEN_W-1:0];
    end else begin
      quot_o = (quo_q > NEG_LIM) ? NEG_SAT : (~quo_q[CEN_W-1:0] + 1'b1);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/core/twc_back.sv @@
// ----------------------------------------------------------------------------
// twc_back
// per-plane accumulation, event-end division and result register
// ----------------------------------------------------------------------------
`include "tot_weighted_centroid_min_tdc_unit_defines.svh"

module twc_back #(
  parameter int unsigned MAX_HITS = twc_pkg::MAX_HITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            op_valid_i,
  input  twc_pkg::twc_op_t                op_i,
  output logic                            op_pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [twc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [twc_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import twc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_HITS + 1);

  twc_plane_t        u_q, u_d, v_q, v_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic signed [PROD_W-1:0] prod;
  logic [WSUM_W-1:0] prod_x;
  logic              pop, out_load;

  twc_div_ctrl_t     div_ctrl;
  twc_div_stat_t     u_stat, v_stat;
  logic [CEN_W-1:0]  u_quot, v_quot;

  // event summary kept while the division runs
  logic              u_ok_q, v_ok_q, res_ovf_q;
  logic [TDC_W-1:0]  u_min_q, v_min_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [OUT_USER_W-1:0] m_user_q;

  function automatic twc_plane_t plane_acc(twc_plane_t p, logic pos, logic tim,
                                           logic [TOT_W-1:0] tot_x,
                                           logic [WSUM_W-1:0] w_x,
                                           logic [TDC_W-1:0] lead);
    twc_plane_t r;
    r = p;
    if (pos) begin
      r.tot  = p.tot + tot_x;
      r.wsum = p.wsum + w_x;
    end
    if (tim && (!p.found || (lead < p.min_tdc))) begin
      r.min_tdc = lead;
      r.found   = 1'b1;
    end
    return r;
  endfunction

  function automatic logic plane_ok(twc_plane_t p);
    return !p.tot[TOT_W-1] && (p.tot != '0) && p.found;
  endfunction

  assign prod   = op_i.tot * op_i.wire_pos;
  assign prod_x = {{(WSUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  // an event end waits until the divider is free and its last result has moved to the result register
  assign pop      = op_valid_i && (!op_i.last || (!u_stat.busy && !u_stat.done));
  assign op_pop_o = pop;
  assign out_load = u_stat.done && (!m_valid_q || m_axis_tready);

  assign div_ctrl.start = pop && op_i.last;
  assign div_ctrl.ack   = out_load;

  always_comb begin
    u_d   = plane_acc(u_q, op_i.u_pos, op_i.u_tim,
                      {{(TOT_W-TOT_OP_W){op_i.tot[TOT_OP_W-1]}}, op_i.tot},
                      prod_x, op_i.lead);
    v_d   = plane_acc(v_q, op_i.v_pos, op_i.v_tim,
                      {{(TOT_W-TOT_OP_W){op_i.tot[TOT_OP_W-1]}}, op_i.tot},
                      prod_x, op_i.lead);
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (op_i.hit) begin
      if (cnt_q >= CNT_W'(MAX_HITS)) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q   <= PLANE_CLR;
      v_q   <= PLANE_CLR;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (pop) begin
      if (op_i.last) begin
        u_q   <= PLANE_CLR;
        v_q   <= PLANE_CLR;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        u_q   <= u_d;
        v_q   <= v_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ctrl.start) begin
      u_ok_q    <= plane_ok(u_d);
      v_ok_q    <= plane_ok(v_d);
      u_min_q   <= u_d.min_tdc;
      v_min_q   <= v_d.min_tdc;
      res_ovf_q <= ovf_d;
    end
  end

  twc_div u_div_u (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (u_d.wsum),
    .divisor_i  (u_d.tot),
    .stat_o     (u_stat),
    .quot_o     (u_quot)
  );

  twc_div u_div_v (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (v_d.wsum),
    .divisor_i  (v_d.tot),
    .stat_o     (v_stat),
    .quot_o     (v_quot)
  );

  // result register, invalid planes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {v_ok_q ? v_min_q : '0, v_ok_q ? v_quot : '0,
                   u_ok_q ? u_min_q : '0, u_ok_q ? u_quot : '0};
      m_user_q <= {res_ovf_q, v_ok_q, u_ok_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `TWC_ASSERT(a_div_start_idle, div_ctrl.start |-> !u_stat.busy && !u_stat.done, "divider restarted")
  `TWC_ASSERT(a_div_lockstep, u_stat.busy == v_stat.busy && u_stat.done == v_stat.done, "dividers apart")
  `TWC_ASSERT(a_clear_after_last, pop && op_i.last |=> cnt_q == '0 && !ovf_q && !u_q.found && !v_q.found, "not cleared")

endmodule

@@ rtl/core/tot_weighted_centroid_min_tdc_unit.sv @@
// ----------------------------------------------------------------------------
// tot_weighted_centroid_min_tdc_unit
// tot weighted wire centroid and minimum leading tdc for two chamber planes
// ----------------------------------------------------------------------------
// path: a hit is accumulated once the back pops it from the queue; an event end
//   gives its result through the queue, a 40-step divider and the result register
// throughput: one hit per cycle while the queue has room; an event end waits until
//   the bit-serial dividers, one per plane and run in parallel, are free again
// reset: layer selects return to u 0/2 and v 3/5, all event sums are cleared
module tot_weighted_centroid_min_tdc_unit #(
  parameter int unsigned MAX_HITS   = twc_pkg::MAX_HITS_DEF,
  parameter int unsigned NUM_LAYERS = twc_pkg::NUM_LAYERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [twc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [twc_pkg::LAYER_W-1:0]     cfg_data_i,
  // hit stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // layer[2:0], lead_tdc[18:3], trailing_tdc[34:19], wire_position[50:35], zero pad
  input  logic [twc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // last_in_event
  input  logic                            s_axis_tlast,
  // hit_present
  input  logic                            s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // u_centroid[15:0], u_min_tdc[31:16], v_centroid[47:32], v_min_tdc[63:48]
  output logic [twc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // u_valid[0], v_valid[1], hit_overflow[2]
  output logic [twc_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import twc_pkg::*;

  twc_cfg_t cfg_q;
  twc_op_t  push_op, pop_op;
  logic     push, full, pop, empty;

  // layer selects; the user writes them only while the unit is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.u_pos <= CFG_RST_U_POS;
      cfg_q.u_tim <= CFG_RST_U_TIM;
      cfg_q.v_pos <= CFG_RST_V_POS;
      cfg_q.v_tim <= CFG_RST_V_TIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_U_POS: cfg_q.u_pos <= cfg_data_i;
        CFG_U_TIM: cfg_q.u_tim <= cfg_data_i;
        CFG_V_POS: cfg_q.v_pos <= cfg_data_i;
        CFG_V_TIM: cfg_q.v_tim <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: classify each hit by the plane roles of its layer
  twc_front #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_front (
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .op_o          (push_op)
  );

  // queue lets the front keep taking hits while the back divides
  twc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_op),
    .empty_o (empty)
  );

  // back: sums, minimum tdc, division at event end, result register
  twc_back #(
    .MAX_HITS (MAX_HITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (!empty),
    .op_i          (pop_op),
    .op_pop_o      (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ sim/tot_weighted_centroid_min_tdc_unit_test.sv @@
// ----------------------------------------------------------------------------
// tot_weighted_centroid_min_tdc_unit_test
// self-checking bench for the two-plane tot weighted centroid unit: hits and
// event ends go in on the slave stream with bursty timing, results come back
// under random back-pressure and are compared field by field with a local
// model of the per-event sums, minimum tdc search and centroid division
// ----------------------------------------------------------------------------
module tot_weighted_centroid_min_tdc_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import twc_pkg::*;

  localparam int unsigned MAX_HITS     = MAX_HITS_DEF;
  localparam int unsigned NUM_LAYERS   = NUM_LAYERS_DEF;
  // a little more than the event end to result latency of the unit
  localparam int          DRAIN_CYCLES = 60;

  // one item on the hit stream
  typedef struct {
    logic                    present;
    logic [LAYER_W-1:0]      layer;
    logic [TDC_W-1:0]        lead;
    logic [TDC_W-1:0]        trail;
    logic signed [POS_W-1:0] wire_pos;
    logic                    last;
  } hit_item_t;

  // running sums of one plane within the current event
  typedef struct {
    logic [WSUM_W-1:0] wsum;
    logic [TOT_W-1:0]  tot;
    logic [TDC_W-1:0]  min_tdc;
    logic              found;
  } plane_sums_t;

  typedef struct {
    logic                    valid;
    logic signed [CEN_W-1:0] centroid;
    logic [TDC_W-1:0]        min_tdc;
  } plane_out_t;

  typedef struct {
    plane_out_t u;
    plane_out_t v;
    logic       overflow;
  } event_result_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [LAYER_W-1:0]     cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // layer[2:0], lead_tdc[18:3], trailing_tdc[34:19], wire_position[50:35], zero pad
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  // last_in_event
  logic                   s_axis_tlast  = 1'b0;
  // hit_present
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // u_centroid[15:0], u_min_tdc[31:16], v_centroid[47:32], v_min_tdc[63:48]
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  // u_valid[0], v_valid[1], hit_overflow[2]
  logic [OUT_USER_W-1:0]  m_axis_tuser;

  // stimulus waiting for the driver, and results waiting for the unit
  hit_item_t     hit_queue[$];
  event_result_t pending_results[$];

  // model copy of the layer selects and the per-event state
  logic [LAYER_W-1:0] sel_u_pos, sel_u_tim, sel_v_pos, sel_v_tim;
  plane_sums_t        u_sums, v_sums;
  int unsigned        event_hits;
  logic               hits_overflowed;

  int error_count   = 0;
  int items_made    = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int settings_used = 1;

  // driver and receiver pacing
  hit_item_t drv_item;
  int        burst_left = 0;
  int        gap_left   = 0;
  int        stall_mode = 0;
  int        stall_left = 0;

  tot_weighted_centroid_min_tdc_unit #(
    .MAX_HITS   (MAX_HITS),
    .NUM_LAYERS (NUM_LAYERS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // model of the unit
  // ---------------------------------------------------------------------------

  function automatic plane_sums_t clear_sums();
    plane_sums_t p;
    p.wsum    = '0;
    p.tot     = '0;
    p.min_tdc = '1;
    p.found   = 1'b0;
    return p;
  endfunction

  // position role adds tot and tot*wire, timing role tracks the smallest lead > 0
  function automatic plane_sums_t add_to_plane(plane_sums_t p, logic [LAYER_W-1:0] pos_layer,
                                               logic [LAYER_W-1:0] tim_layer, hit_item_t h);
    longint tot_val;
    longint prod;
    if (h.layer == pos_layer) begin
      tot_val = longint'(h.trail) - longint'(h.lead);
      prod    = tot_val * longint'(h.wire_pos);
      p.tot   = p.tot + tot_val[TOT_W-1:0];
      p.wsum  = p.wsum + prod[WSUM_W-1:0];
    end
    if (h.layer == tim_layer && h.lead != 0) begin
      if (!p.found || h.lead < p.min_tdc) begin
        p.min_tdc = h.lead;
        p.found   = 1'b1;
      end
    end
    return p;
  endfunction

  // signed division truncates toward zero, then clamps to 16 bits
  function automatic plane_out_t plane_centroid(plane_sums_t p);
    plane_out_t o;
    longint     tot_s;
    longint     wsum_s;
    longint     quot;
    tot_s  = longint'($signed(p.tot));
    wsum_s = longint'($signed(p.wsum));
    o.valid    = 1'b0;
    o.centroid = '0;
    o.min_tdc  = '0;
    if (tot_s > 0 && p.found) begin
      quot = wsum_s / tot_s;
      if (quot > 32767) quot = 32767;
      if (quot < -32768) quot = -32768;
      o.valid    = 1'b1;
      o.centroid = quot[CEN_W-1:0];
      o.min_tdc  = p.min_tdc;
    end
    return o;
  endfunction

  // called for every item the unit takes; queues a result on an event end
  task automatic accumulate_hit(hit_item_t h);
    event_result_t r;
    if (h.present) begin
      if (event_hits >= MAX_HITS) hits_overflowed = 1'b1;
      else event_hits++;
      // layers past the last chamber layer count as hits but feed no plane
      if (h.layer < NUM_LAYERS) begin
        u_sums = add_to_plane(u_sums, sel_u_pos, sel_u_tim, h);
        v_sums = add_to_plane(v_sums, sel_v_pos, sel_v_tim, h);
      end
    end
    if (h.last) begin
      r.u        = plane_centroid(u_sums);
      r.v        = plane_centroid(v_sums);
      r.overflow = hits_overflowed;
      pending_results.push_back(r);
      u_sums          = clear_sums();
      v_sums          = clear_sums();
      event_hits      = 0;
      hits_overflowed = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got)
      flag_error($sformatf("result %0d %s: expected %0d, got %0d", results_seen, name, want,
                           got));
  endtask

  task automatic check_result();
    event_result_t exp_r;
    if (pending_results.size() == 0) begin
      flag_error($sformatf("result with no event end pending, tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser));
    end else begin
      exp_r = pending_results.pop_front();
      check_field("u_valid", exp_r.u.valid, m_axis_tuser[0]);
      check_field("u_centroid", exp_r.u.centroid, $signed(m_axis_tdata[15:0]));
      check_field("u_min_tdc", exp_r.u.min_tdc, m_axis_tdata[31:16]);
      check_field("v_valid", exp_r.v.valid, m_axis_tuser[1]);
      check_field("v_centroid", exp_r.v.centroid, $signed(m_axis_tdata[47:32]));
      check_field("v_min_tdc", exp_r.v.min_tdc, m_axis_tdata[63:48]);
      check_field("hit_overflow", exp_r.overflow, m_axis_tuser[2]);
    end
    results_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of items with random gaps, some bursts long enough to
  // run at full rate for a while
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      accumulate_hit(drv_item);
      items_taken++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (hit_queue.size() != 0) begin
        drv_item = hit_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, drv_item.wire_pos, drv_item.trail, drv_item.lead,
                          drv_item.layer};
        s_axis_tlast  <= drv_item.last;
        s_axis_tuser  <= drv_item.present;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks accepted results; ready follows a pattern that is redrawn at
  // random times (always ready, coin flip, mostly stalled, periodic)
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 5) == 0);
      end
      default: begin
        m_axis_tready <= (stall_left % 7) < 3;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_item(hit_item_t h);
    hit_queue.push_back(h);
    // items the unit merely skips do not count toward the budget
    if (h.present || h.last) items_made++;
  endtask

  task automatic push_hit(bit present, int layer, int lead, int trail, int wire_val, bit last);
    hit_item_t h;
    h.present  = present;
    h.layer    = layer[LAYER_W-1:0];
    h.lead     = lead[TDC_W-1:0];
    h.trail    = trail[TDC_W-1:0];
    h.wire_pos = wire_val[POS_W-1:0];
    h.last     = last;
    push_item(h);
  endtask

  // mostly hits on the selected layers, tot mostly positive and moderate
  function automatic hit_item_t random_hit(bit last);
    hit_item_t h;
    int        lead_v;
    int        trail_v;
    int        pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      case ($urandom_range(0, 3))
        0:       h.layer = sel_u_pos;
        1:       h.layer = sel_u_tim;
        2:       h.layer = sel_v_pos;
        default: h.layer = sel_v_tim;
      endcase
    end else begin
      h.layer = LAYER_W'($urandom_range(0, 7));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) lead_v = 0;
    else if (pick < 5) lead_v = $urandom_range(1, 400);
    else lead_v = $urandom_range(0, 65535);
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      trail_v = lead_v + $urandom_range(0, 4000);
      if (trail_v > 65535) trail_v = 65535;
    end else if (pick < 9) begin
      // trailing edge before the leading edge
      trail_v = lead_v - $urandom_range(1, 200);
      if (trail_v < 0) trail_v = 0;
    end else begin
      trail_v = $urandom_range(0, 65535);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) h.wire_pos = 16'sh7fff;
    else if (pick == 1) h.wire_pos = 16'sh8000;
    else h.wire_pos = POS_W'($urandom_range(0, 65535));
    h.present = 1'b1;
    h.lead    = lead_v[TDC_W-1:0];
    h.trail   = trail_v[TDC_W-1:0];
    h.last    = last;
    return h;
  endfunction

  // item with no hit and random payload, which the unit must ignore unless it ends an event
  function automatic hit_item_t blank_item(bit last);
    hit_item_t h;
    h.present  = 1'b0;
    h.layer    = LAYER_W'($urandom_range(0, 7));
    h.lead     = TDC_W'($urandom_range(0, 65535));
    h.trail    = TDC_W'($urandom_range(0, 65535));
    h.wire_pos = POS_W'($urandom_range(0, 65535));
    h.last     = last;
    return h;
  endfunction

  // one event of n hits; ends on a hit or on a separate empty end marker
  task automatic add_event(int n_hits);
    bit end_on_hit;
    end_on_hit = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n_hits; i++) begin
      push_item(random_hit(end_on_hit && i == n_hits - 1));
      if ($urandom_range(0, 19) == 0) push_item(blank_item(1'b0));
    end
    if (!end_on_hit) push_item(blank_item(1'b1));
  endtask

  task automatic random_events(int budget, int overflow_hits);
    int start_count;
    int pick;
    start_count = items_made;
    // one event near the hit limit per setting, the rest mostly short
    add_event(overflow_hits);
    while (items_made - start_count < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) push_item(blank_item(1'b0));
      else if (pick < 10) push_item(blank_item(1'b1));
      else if (pick < 12) add_event($urandom_range(60, 72));
      else add_event($urandom_range(1, 12));
    end
  endtask

  // hold until every item is taken and every result has come back
  task automatic settle();
    while (hit_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_layer(twc_cfg_idx_e idx, logic [LAYER_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_U_POS: sel_u_pos = val;
      CFG_U_TIM: sel_u_tim = val;
      CFG_V_POS: sel_v_pos = val;
      default:   sel_v_tim = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_layers(int u_pos, int u_tim, int v_pos, int v_tim);
    write_layer(CFG_U_POS, u_pos[LAYER_W-1:0]);
    write_layer(CFG_U_TIM, u_tim[LAYER_W-1:0]);
    write_layer(CFG_V_POS, v_pos[LAYER_W-1:0]);
    write_layer(CFG_V_TIM, v_tim[LAYER_W-1:0]);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    sel_u_pos       = CFG_RST_U_POS;
    sel_u_tim       = CFG_RST_U_TIM;
    sel_v_pos       = CFG_RST_V_POS;
    sel_v_tim       = CFG_RST_V_TIM;
    u_sums          = clear_sums();
    v_sums          = clear_sums();
    event_hits      = 0;
    hits_overflowed = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed events on the reset layer selects (u 0/2, v 3/5)
    // empty event end, then a blank item that must be skipped
    push_hit(0, 7, 65535, 65535, 32767, 1);
    push_hit(0, 0, 5, 9, 100, 0);
    // zero lead never becomes the minimum; ends on an ignored layer hit
    push_hit(1, 0, 100, 300, 32767, 0);
    push_hit(1, 2, 0, 0, 0, 0);
    push_hit(1, 2, 50, 60, 5, 0);
    push_hit(1, 2, 65535, 0, -1, 0);
    push_hit(1, 0, 200, 100, -32768, 0);
    push_hit(1, 6, 1, 2, 3, 1);
    // u centroid far below range, v at full tot and largest lead
    push_hit(1, 0, 0, 2, -32768, 0);
    push_hit(1, 0, 1, 0, 32767, 0);
    push_hit(1, 2, 7, 9, 0, 0);
    push_hit(1, 3, 0, 65535, 32767, 0);
    push_hit(1, 5, 65535, 1, 0, 0);
    push_hit(1, 7, 3, 4, 5, 0);
    push_hit(0, 3, 1, 1, 1, 1);
    // u centroid far above range
    push_hit(1, 0, 0, 2, 32767, 0);
    push_hit(1, 0, 1, 0, -32768, 0);
    push_hit(1, 2, 1, 1, 0, 1);
    // v tot negative, u has a timing hit but no position hit
    push_hit(1, 3, 65535, 0, -32768, 0);
    push_hit(1, 5, 1, 1, 0, 0);
    push_hit(1, 2, 1, 0, 0, 1);
    random_events(170, 63);
    settle();

    // one layer in every role of both planes
    set_layers(0, 0, 0, 0);
    random_events(190, 64);
    settle();

    // top chamber layer everywhere, plus a long event that wraps both sums
    set_layers(5, 5, 5, 5);
    for (int i = 0; i < 260; i++) push_hit(1, 5, 1, 65535, -32768, i == 259);
    random_events(170, 65);
    settle();

    // u selects name layers past the last chamber layer, whose hits feed no plane
    set_layers(7, 6, 1, 4);
    random_events(190, 66);
    settle();

    set_layers(4, 1, 7, 7);
    random_events(170, 67);
    settle();

    set_layers($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
               $urandom_range(0, 7));
    random_events(190, 80);
    settle();

    $display("run covered %0d hit stream items and %0d event results", items_taken,
             results_seen);
    $display("over %0d layer select settings, including unused and shared layers",
             settings_used);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d items queued and %0d results pending", hit_queue.size(),
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/twc_pkg.sv
rtl/core/twc_fifo.sv
rtl/core/twc_front.sv
rtl/core/twc_div.sv
rtl/core/twc_back.sv
rtl/core/tot_weighted_centroid_min_tdc_unit.sv
sim/tot_weighted_centroid_min_tdc_unit_test.sv
